// ===== rtl/byte_isa_cpu_step_unit_assert.svh =====
// assertion macros used by the rtl core
`ifndef BYTE_ISA_CPU_STEP_UNIT_ASSERT_SVH
`define BYTE_ISA_CPU_STEP_UNIT_ASSERT_SVH
// condition implies consequent in the same cycle
`define BICS_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// condition implies consequent in the next cycle
`define BICS_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/bics_pkg.sv =====
// package: constants, opcodes, state and payload types
package bics_pkg;
  localparam int MemBytes = 16384;
  localparam int AddrW = $clog2(MemBytes);
  localparam int NumRegs = 16;
  localparam int PcW = 28;

  typedef enum logic [3:0] {
    OP_HALT = 4'd0, OP_ADD = 4'd1, OP_AND = 4'd2, OP_DIV = 4'd3, OP_MUL = 4'd4,
    OP_SUB = 4'd5, OP_OR = 4'd6, OP_SHF = 4'd7, OP_INT = 4'd8, OP_ADDI = 4'd9,
    OP_BEQ = 4'd10, OP_BLT = 4'd11, OP_JMP = 4'd12, OP_ITER = 4'd13,
    OP_LD = 4'd14, OP_ST = 4'd15
  } op_t;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_STEP = 2'd1;
  localparam logic [1:0] KIND_REGD = 2'd2;
  localparam logic [1:0] KIND_MEMD = 2'd3;
  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_ODD = 2'd1;
  localparam logic [1:0] FLT_DIV0 = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_FWAIT, S_DECODE, S_DIV, S_DIVFIX, S_MUL,
    S_MEMRD, S_MEMWAIT, S_ITERCHK, S_DUMP, S_DUMPRD, S_DUMPWAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic       req_type;
    logic [13:0] load_addr;
    logic [7:0] load_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [27:0] next_pc;
    logic        halted;
    logic [1:0]  fault;
    logic        reg_written;
    logic [3:0]  dest_index;
    logic signed [31:0] dest_value;
    logic [3:0]  dump_index;
    logic signed [31:0] dump_value;
    logic        last;
  } out_t;
endpackage

// ===== rtl/bics_if.sv =====
// valid/ready channel carrying one payload
interface bics_in_if;
  logic valid;
  logic ready;
  bics_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bics_out_if;
  logic valid;
  logic ready;
  bics_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/byte_isa_cpu_step_unit.sv =====
// byte_isa_cpu_step_unit: multicycle core for a 16-register byte-memory isa
// Channel in (bics_in_if sink): req_type 0 writes load_byte at load_addr,
// req_type 1 executes the instruction at the program counter.
// Channel out (bics_out_if source): one beat per result; last marks the
// final beat of an item. Load and step items give one beat, interrupt 0
// gives 16 register lines, interrupt 1 one memory line per nonzero register
// or a step beat if none. One item is taken at a time; in is low while an item
// is in work. A load writes its byte on accept and its beat is registered in
// the output state; a step fetches its 2 or 4 bytes one by one from the
// single-port memory, and a byte load or an iterate adds a memory read. Multiply
// is a shift-add over the 32 multiplier bits and divide a restoring loop over the
// 32 dividend bits plus sign fix, on separate adders. The next item is taken only
// after the last beat has gone out. Each dump line waits for the one before it;
// a memory dump reads the byte that each nonzero register points at. After reset
// the memory is swept to zero, one byte a cycle over all 16384 bytes, before the
// first item is accepted; registers, pc and halt flag clear at once.
// When the receiver stalls the result beat holds in the output register and
// the block waits; nothing is dropped.
`include "byte_isa_cpu_step_unit_assert.svh"
module byte_isa_cpu_step_unit (
  input logic clk,
  input logic rst,
  bics_in_if.sink   in,
  bics_out_if.source out
);
  localparam int AW = bics_pkg::AddrW;

  bics_pkg::state_t state, state_next;
  logic [31:0] regs [bics_pkg::NumRegs];
  logic [27:0] pc;
  logic        halt;
  logic [AW-1:0] clr_addr;
  logic [7:0]  b0, b1, b2;
  logic [1:0]  fidx;
  logic [31:0] acc, opa, opb;
  logic [5:0]  cnt;
  logic        neg;
  logic [4:0]  dreg;
  bics_pkg::out_t obuf;
  logic        ovalid;
  logic        dump_mem;
  logic [31:0] quot;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  bics_ram #(.Width(8), .Depth(bics_pkg::MemBytes)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  bics_pkg::op_t op;
  logic [31:0] x, y, noff, eaddr, boff;
  logic [27:0] fpc;
  assign op = bics_pkg::op_t'(b0[7:4]);
  assign x = regs[b0[3:0]];
  assign y = regs[b1[7:4]];
  assign noff = {{28{b1[3]}}, b1[3:0]};
  assign eaddr = y + noff;
  assign boff = {{12{b1[3]}}, b1[3:0], b2, mem_rdata};
  assign fpc = pc + 28'(fidx);

  logic four;
  assign four = (op == bics_pkg::OP_BEQ) || (op == bics_pkg::OP_BLT) ||
                (op == bics_pkg::OP_JMP) || (op == bics_pkg::OP_ITER);

  // two adders: subtract for division, add for multiply
  logic [32:0] dsub;
  logic [31:0] rem_sh;
  assign rem_sh = {acc[30:0], opa[31]};
  assign dsub = {1'b0, rem_sh} - {1'b0, opb};
  logic [31:0] madd;
  assign madd = acc + (opa[0] ? opb : 32'd0);

  // skip to next nonzero register for memory dump
  logic [4:0] nz_first, nz_after;
  always_comb begin
    nz_first = 5'd16;
    for (int i = bics_pkg::NumRegs - 1; i >= 0; i--) begin
      if (regs[i] != 32'd0) nz_first = 5'(i);
    end
    nz_after = 5'd16;
    for (int i = bics_pkg::NumRegs - 1; i >= 0; i--) begin
      if (regs[i] != 32'd0 && 5'(i) > dreg) nz_after = 5'(i);
    end
  end

  assign in.ready = (state == bics_pkg::S_IDLE) && !ovalid;
  assign out.valid = ovalid;
  assign out.data = obuf;

  logic accept;
  assign accept = in.valid && in.ready;

  function automatic bics_pkg::out_t mk_beat(logic [1:0] kind, logic [27:0] npc, logic hlt,
                                             logic [3:0] idx, logic [31:0] val, logic lst);
    bics_pkg::out_t r;
    r = '0;
    r.kind = kind;
    r.next_pc = npc;
    r.halted = hlt;
    r.dump_index = idx;
    r.dump_value = val;
    r.last = lst;
    return r;
  endfunction

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_addr = fpc[AW-1:0];
    mem_wdata = 8'd0;
    unique case (state)
      bics_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_addr;
        if (clr_addr == AW'(bics_pkg::MemBytes - 1)) state_next = bics_pkg::S_IDLE;
      end
      bics_pkg::S_IDLE: begin
        if (accept) begin
          if (!in.data.req_type) begin
            mem_we = 1'b1;
            mem_addr = in.data.load_addr[AW-1:0];
            mem_wdata = in.data.load_byte;
            state_next = bics_pkg::S_OUT;
          end else if (halt) state_next = bics_pkg::S_OUT;
          else state_next = bics_pkg::S_FETCH;
        end
      end
      bics_pkg::S_FETCH: state_next = bics_pkg::S_FWAIT;
      bics_pkg::S_FWAIT: begin
        if ((fidx == 2'd1 && !four) || fidx == 2'd3) state_next = bics_pkg::S_DECODE;
        else state_next = bics_pkg::S_FETCH;
      end
      bics_pkg::S_DECODE: begin
        mem_addr = eaddr[AW-1:0];
        unique case (op)
          bics_pkg::OP_DIV: state_next = (y == 32'd0) ? bics_pkg::S_OUT : bics_pkg::S_DIV;
          bics_pkg::OP_MUL: state_next = bics_pkg::S_MUL;
          bics_pkg::OP_LD: state_next = bics_pkg::S_MEMRD;
          bics_pkg::OP_ST: begin
            mem_we = 1'b1;
            mem_wdata = x[7:0];
            state_next = bics_pkg::S_OUT;
          end
          bics_pkg::OP_ITER: begin
            mem_addr = x[AW-1:0];
            state_next = bics_pkg::S_MEMRD;
          end
          bics_pkg::OP_INT: state_next = bics_pkg::S_DUMP;
          default: state_next = bics_pkg::S_OUT;
        endcase
      end
      bics_pkg::S_DIV: if (cnt == 6'd31) state_next = bics_pkg::S_DIVFIX;
      bics_pkg::S_DIVFIX: state_next = bics_pkg::S_OUT;
      bics_pkg::S_MUL: if (cnt == 6'd31) state_next = bics_pkg::S_OUT;
      bics_pkg::S_MEMRD: begin
        // hold the data address so the read is still there next cycle
        mem_addr = (op == bics_pkg::OP_ITER) ? x[AW-1:0] : eaddr[AW-1:0];
        state_next = bics_pkg::S_MEMWAIT;
      end
      bics_pkg::S_MEMWAIT: state_next = bics_pkg::S_OUT;
      bics_pkg::S_ITERCHK: state_next = bics_pkg::S_OUT;
      bics_pkg::S_DUMP: begin
        if (!ovalid) begin
          if (dreg[4] || (!dump_mem && dreg == 5'd15)) state_next = bics_pkg::S_IDLE;
          else if (dump_mem) state_next = bics_pkg::S_DUMPRD;
        end
      end
      bics_pkg::S_DUMPRD: begin
        mem_addr = regs[dreg[3:0]][AW-1:0];
        state_next = bics_pkg::S_DUMPWAIT;
      end
      bics_pkg::S_DUMPWAIT: state_next = nz_after[4] ? bics_pkg::S_IDLE : bics_pkg::S_DUMP;
      bics_pkg::S_OUT: if (!ovalid) state_next = bics_pkg::S_IDLE;
      default: state_next = bics_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bics_pkg::S_CLEAR;
      clr_addr <= '0;
      pc <= '0;
      halt <= 1'b0;
      ovalid <= 1'b0;
      for (int i = 0; i < bics_pkg::NumRegs; i++) regs[i] <= '0;
    end else begin
      state <= state_next;
      if (ovalid && out.ready) ovalid <= 1'b0;
      unique case (state)
        bics_pkg::S_CLEAR: clr_addr <= clr_addr + AW'(1);
        bics_pkg::S_IDLE: begin
          if (accept) begin
            fidx <= 2'd0;
            obuf <= mk_beat(in.data.req_type ? bics_pkg::KIND_STEP : bics_pkg::KIND_LOAD,
                            pc, halt, 4'd0, 32'd0, 1'b1);
          end
        end
        bics_pkg::S_FETCH: ;
        bics_pkg::S_FWAIT: begin
          unique case (fidx)
            2'd0: b0 <= mem_rdata;
            2'd1: b1 <= mem_rdata;
            2'd2: b2 <= mem_rdata;
            default: ;
          endcase
          if (!((fidx == 2'd1 && !four) || fidx == 2'd3)) fidx <= fidx + 2'd1;
        end
        bics_pkg::S_DECODE: begin
          cnt <= '0;
          unique case (op)
            bics_pkg::OP_HALT: halt <= 1'b1;
            bics_pkg::OP_ADD, bics_pkg::OP_AND, bics_pkg::OP_SUB, bics_pkg::OP_OR,
            bics_pkg::OP_SHF, bics_pkg::OP_ADDI: begin
              obuf.reg_written <= 1'b1;
              obuf.dest_index <= (op == bics_pkg::OP_SHF || op == bics_pkg::OP_ADDI)
                                 ? b0[3:0] : b1[3:0];
              unique case (op)
                bics_pkg::OP_ADD: acc <= x + y;
                bics_pkg::OP_AND: acc <= x & y;
                bics_pkg::OP_SUB: acc <= x - y;
                bics_pkg::OP_OR: acc <= x | y;
                bics_pkg::OP_SHF: acc <= b1[5] ? 32'($signed(x) >>> b1[4:0]) : x << b1[4:0];
                default: acc <= x + {{24{b1[7]}}, b1};
              endcase
              pc <= pc + 28'd2;
            end
            bics_pkg::OP_DIV: begin
              if (y == 32'd0) begin
                halt <= 1'b1;
                obuf.fault <= bics_pkg::FLT_DIV0;
              end else begin
                opa <= x[31] ? -x : x;
                opb <= y[31] ? -y : y;
                neg <= x[31] ^ y[31];
                acc <= '0;
              end
            end
            bics_pkg::OP_MUL: begin
              opa <= x;
              opb <= y;
              acc <= '0;
            end
            bics_pkg::OP_BEQ, bics_pkg::OP_BLT: begin
              if ((op == bics_pkg::OP_BEQ) ? (x == y) : ($signed(x) < $signed(y))) begin
                if (boff == 32'd0) pc <= pc + 28'd4;
                else if (boff[0]) begin
                  halt <= 1'b1;
                  obuf.fault <= bics_pkg::FLT_ODD;
                end else pc <= pc + boff[27:0];
              end else pc <= pc + 28'd4;
            end
            bics_pkg::OP_JMP: pc <= {b0[3:0], b1, b2, mem_rdata};
            bics_pkg::OP_INT: begin
              pc <= pc + 28'd2;
              dump_mem <= ({b0[3:0], b1} == 12'd1);
              dreg <= ({b0[3:0], b1} == 12'd0) ? 5'd0 :
                      ({b0[3:0], b1} == 12'd1) ? nz_first : 5'd16;
            end
            bics_pkg::OP_ITER: b2 <= b2; // b2 kept, byte 3 held below
            bics_pkg::OP_ST: pc <= pc + 28'd2;
            default: ;
          endcase
          if (op == bics_pkg::OP_ITER) opb <= {16'd0, b2, mem_rdata};
        end
        bics_pkg::S_DIV: begin
          cnt <= cnt + 6'd1;
          opa <= {opa[30:0], 1'b0};
          if (!dsub[32]) begin
            acc <= dsub[31:0];
            opb <= opb;
          end else acc <= rem_sh;
        end
        bics_pkg::S_DIVFIX: begin
          acc <= neg ? -quot : quot;
          obuf.reg_written <= 1'b1;
          obuf.dest_index <= b1[3:0];
          pc <= pc + 28'd2;
        end
        bics_pkg::S_MUL: begin
          cnt <= cnt + 6'd1;
          acc <= madd;
          opa <= {1'b0, opa[31:1]};
          opb <= {opb[30:0], 1'b0};
          if (cnt == 6'd31) begin
            obuf.reg_written <= 1'b1;
            obuf.dest_index <= b1[3:0];
            pc <= pc + 28'd2;
          end
        end
        bics_pkg::S_MEMRD: ;
        bics_pkg::S_MEMWAIT: begin
          if (op == bics_pkg::OP_LD) begin
            acc <= {24'd0, mem_rdata};
            obuf.reg_written <= 1'b1;
            obuf.dest_index <= b0[3:0];
            pc <= pc + 28'd2;
          end else if (mem_rdata != 8'd0) begin
            acc <= x + {24'd0, b1};
            obuf.reg_written <= 1'b1;
            obuf.dest_index <= b0[3:0];
            pc <= pc - opb[27:0];
          end else pc <= pc + 28'd4;
        end
        bics_pkg::S_ITERCHK: ;
        bics_pkg::S_DUMP: begin
          if (!ovalid) begin
            if (dreg[4]) begin
              ovalid <= 1'b1;
              obuf <= mk_beat(bics_pkg::KIND_STEP, pc, halt, 4'd0, 32'd0, 1'b1);
            end else if (!dump_mem) begin
              ovalid <= 1'b1;
              obuf <= mk_beat(bics_pkg::KIND_REGD, pc, halt, dreg[3:0], regs[dreg[3:0]],
                              dreg == 5'd15);
              dreg <= dreg + 5'd1;
            end
          end
        end
        bics_pkg::S_DUMPRD: ;
        bics_pkg::S_DUMPWAIT: begin
          ovalid <= 1'b1;
          obuf <= mk_beat(bics_pkg::KIND_MEMD, pc, halt, dreg[3:0], {24'd0, mem_rdata},
                          nz_after[4]);
          dreg <= nz_after;
        end
        bics_pkg::S_OUT: begin
          if (!ovalid) begin
            ovalid <= 1'b1;
            obuf.next_pc <= pc;
            obuf.halted <= halt;
            if (obuf.reg_written) begin
              obuf.dest_value <= acc;
              regs[obuf.dest_index] <= acc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // quotient collects in a register of its own
  always_ff @(posedge clk) begin
    if (state == bics_pkg::S_DIV) quot <= {quot[30:0], !dsub[32]};
  end

  `BICS_ASSERT_IMP(a_busy_not_ready, clk, rst, state != bics_pkg::S_IDLE, !in.ready,
    "input ready while busy")
  `BICS_ASSERT_NEXT(a_load_one_beat, clk, rst, accept && !in.data.req_type,
    state == bics_pkg::S_OUT, "load did not go to output")
  `BICS_ASSERT_IMP(a_regd_last, clk, rst,
    out.valid && out.data.kind == bics_pkg::KIND_REGD && out.data.last,
    out.data.dump_index == 4'd15, "register dump ends early")
  `BICS_ASSERT_IMP(a_fault_halts, clk, rst, out.valid && out.data.fault != bics_pkg::FLT_NONE,
    out.data.halted, "fault without halt")
endmodule

// ===== rtl/bics_ram.sv =====
// generic single-port ram with registered read
module bics_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== verif/bics_step_checker.sv =====
// checker: watches both channels, predicts each result beat and compares it
module bics_step_checker (
  input  logic       clk,
  input  logic       rst,
  bics_in_if         in_ch,
  bics_out_if        out_ch,
  output int         fails,
  output int         pending
);
  localparam int NumRegs = bics_pkg::NumRegs;
  localparam int MemBytes = bics_pkg::MemBytes;
  localparam int AddrW = bics_pkg::AddrW;
  localparam int PcW = bics_pkg::PcW;

  logic [31:0]    regs [NumRegs];
  logic [7:0]     mem_img [MemBytes];
  logic [PcW-1:0] pc_q;
  logic           halt_q;
  bics_pkg::out_t due_q [$];

  function automatic void emit(logic [1:0] kind, logic [1:0] flt, logic wr, logic [3:0] di,
                               logic [31:0] dv, logic [3:0] xi, logic [31:0] xv, logic lst);
    bics_pkg::out_t r;
    r.kind = kind;
    r.next_pc = pc_q;
    r.halted = halt_q;
    r.fault = flt;
    r.reg_written = wr;
    r.dest_index = wr ? di : 4'd0;
    r.dest_value = wr ? dv : 32'd0;
    r.dump_index = xi;
    r.dump_value = xv;
    r.last = lst;
    due_q.push_back(r);
  endfunction

  task automatic run_item(bics_pkg::in_t it);
    logic [7:0]     b [4];
    logic [PcW-1:0] fa, npc;
    bics_pkg::op_t  op;
    logic [3:0]     ra, rb, di;
    logic [31:0]    x, y, dv, off, ma, mb, q, ad;
    logic [1:0]     flt;
    logic           wr, take;
    logic [11:0]    code;
    int             last_nz, n;
    if (!it.req_type) begin
      mem_img[it.load_addr] = it.load_byte;
      emit(bics_pkg::KIND_LOAD, bics_pkg::FLT_NONE, 1'b0, 4'd0, 32'd0, 4'd0, 32'd0, 1'b1);
      return;
    end
    if (halt_q) begin
      emit(bics_pkg::KIND_STEP, bics_pkg::FLT_NONE, 1'b0, 4'd0, 32'd0, 4'd0, 32'd0, 1'b1);
      return;
    end
    for (int i = 0; i < 4; i++) begin
      fa = pc_q + PcW'(i);
      b[i] = mem_img[fa[AddrW-1:0]];
    end
    op = bics_pkg::op_t'(b[0][7:4]);
    ra = b[0][3:0];
    rb = b[1][7:4];
    x = regs[ra];
    y = regs[rb];
    npc = pc_q;
    flt = bics_pkg::FLT_NONE;
    wr = 1'b0;
    di = 4'd0;
    dv = 32'd0;
    case (op)
      bics_pkg::OP_HALT: halt_q = 1'b1;
      bics_pkg::OP_ADD, bics_pkg::OP_AND, bics_pkg::OP_DIV, bics_pkg::OP_MUL,
      bics_pkg::OP_SUB, bics_pkg::OP_OR: begin
        if (op == bics_pkg::OP_DIV && y == 32'd0) begin
          flt = bics_pkg::FLT_DIV0;
          halt_q = 1'b1;
        end else begin
          case (op)
            bics_pkg::OP_ADD: dv = x + y;
            bics_pkg::OP_AND: dv = x & y;
            bics_pkg::OP_DIV: begin
              ma = x[31] ? -x : x;
              mb = y[31] ? -y : y;
              q = ma / mb;
              dv = (x[31] ^ y[31]) ? -q : q;
            end
            bics_pkg::OP_MUL: dv = x * y;
            bics_pkg::OP_SUB: dv = x - y;
            default: dv = x | y;
          endcase
          wr = 1'b1;
          di = b[1][3:0];
          npc = pc_q + PcW'(2);
        end
      end
      bics_pkg::OP_SHF: begin
        dv = b[1][5] ? 32'($signed(x) >>> b[1][4:0]) : x << b[1][4:0];
        wr = 1'b1;
        di = ra;
        npc = pc_q + PcW'(2);
      end
      bics_pkg::OP_INT: begin
        code = {ra, b[1]};
        pc_q = pc_q + PcW'(2);
        if (code == 12'd0) begin
          for (int i = 0; i < NumRegs; i++)
            emit(bics_pkg::KIND_REGD, bics_pkg::FLT_NONE, 1'b0, 4'd0, 32'd0, 4'(i), regs[i],
                 i == NumRegs - 1);
          return;
        end
        n = 0;
        if (code == 12'd1) begin
          last_nz = -1;
          for (int i = 0; i < NumRegs; i++)
            if (regs[i] != 32'd0) last_nz = i;
          for (int i = 0; i < NumRegs; i++)
            if (regs[i] != 32'd0) begin
              emit(bics_pkg::KIND_MEMD, bics_pkg::FLT_NONE, 1'b0, 4'd0, 32'd0, 4'(i),
                   {24'd0, mem_img[regs[i][AddrW-1:0]]}, i == last_nz);
              n++;
            end
        end
        if (n == 0)
          emit(bics_pkg::KIND_STEP, bics_pkg::FLT_NONE, 1'b0, 4'd0, 32'd0, 4'd0, 32'd0, 1'b1);
        return;
      end
      bics_pkg::OP_ADDI: begin
        dv = x + {{24{b[1][7]}}, b[1]};
        wr = 1'b1;
        di = ra;
        npc = pc_q + PcW'(2);
      end
      bics_pkg::OP_BEQ, bics_pkg::OP_BLT: begin
        take = (op == bics_pkg::OP_BEQ) ? (x == y) : ($signed(x) < $signed(y));
        off = {{12{b[1][3]}}, b[1][3:0], b[2], b[3]};
        if (!take || off == 32'd0) npc = pc_q + PcW'(4);
        else if (off[0]) begin
          flt = bics_pkg::FLT_ODD;
          halt_q = 1'b1;
        end else npc = pc_q + off[PcW-1:0];
      end
      bics_pkg::OP_JMP: npc = {ra, b[1], b[2], b[3]};
      bics_pkg::OP_ITER: begin
        if (mem_img[x[AddrW-1:0]] != 8'd0) begin
          dv = x + {24'd0, b[1]};
          wr = 1'b1;
          di = ra;
          npc = pc_q - {12'd0, b[2], b[3]};
        end else npc = pc_q + PcW'(4);
      end
      bics_pkg::OP_LD: begin
        ad = y + {{28{b[1][3]}}, b[1][3:0]};
        dv = {24'd0, mem_img[ad[AddrW-1:0]]};
        wr = 1'b1;
        di = ra;
        npc = pc_q + PcW'(2);
      end
      default: begin
        ad = y + {{28{b[1][3]}}, b[1][3:0]};
        mem_img[ad[AddrW-1:0]] = x[7:0];
        npc = pc_q + PcW'(2);
      end
    endcase
    if (wr) regs[di] = dv;
    pc_q = npc;
    emit(bics_pkg::KIND_STEP, flt, wr, di, dv, 4'd0, 32'd0, 1'b1);
  endtask

  task automatic chk(string fname, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, e, a);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    bics_pkg::out_t e, a;
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] = 32'd0;
      for (int i = 0; i < MemBytes; i++) mem_img[i] = 8'd0;
      pc_q = '0;
      halt_q = 1'b0;
      due_q.delete();
      fails = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) run_item(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.data;
        if (due_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, a);
          fails++;
        end else begin
          e = due_q.pop_front();
          chk("kind", 32'(e.kind), 32'(a.kind));
          chk("next_pc", 32'(e.next_pc), 32'(a.next_pc));
          chk("halted", 32'(e.halted), 32'(a.halted));
          chk("fault", 32'(e.fault), 32'(a.fault));
          chk("reg_written", 32'(e.reg_written), 32'(a.reg_written));
          chk("dest_index", 32'(e.dest_index), 32'(a.dest_index));
          chk("dest_value", e.dest_value, a.dest_value);
          chk("dump_index", 32'(e.dump_index), 32'(a.dump_index));
          chk("dump_value", e.dump_value, a.dump_value);
          chk("last", 32'(e.last), 32'(a.last));
        end
      end
    end
    pending = due_q.size();
  end
endmodule

// ===== verif/tb.sv =====
// testbench top: clock, reset, program stimulus, receiver stalls and verdict
module tb;
  localparam int PcW = bics_pkg::PcW;
  localparam int AddrW = bics_pkg::AddrW;
  localparam int MemBytes = bics_pkg::MemBytes;

  localparam int WatchLimit = 60000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails, pending;
  int   n_items = 0;
  int   idle_cnt = 0;
  bit   quiet = 1'b0;
  logic [PcW-1:0] cur_pc = '0;

  bics_in_if  in_ch ();
  bics_out_if out_ch ();

  byte_isa_cpu_step_unit u_dut (.clk(clk), .rst(rst), .in(in_ch), .out(out_ch));

  bics_step_checker u_chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .fails(fails), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // no beat on either channel for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      $display("[byte_isa_cpu_step_unit] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off once results are flowing
  initial begin
    int  beats;
    bit  held;
    beats = 0;
    held = 1'b0;
    out_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) beats++;
      if (beats >= 30 && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);
      end
    end
  end

  task automatic send(logic rt, logic [AddrW-1:0] ad, logic [7:0] v);
    bics_pkg::in_t it;
    if (!quiet && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    it.req_type = rt;
    it.load_addr = ad;
    it.load_byte = v;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_items++;
  endtask

  task automatic poke(logic [PcW-1:0] ad, logic [7:0] v);
    send(1'b0, ad[AddrW-1:0], v);
  endtask

  task automatic step();
    send(1'b1, AddrW'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic exec2(logic [7:0] b0, logic [7:0] b1);
    poke(cur_pc, b0);
    poke(cur_pc + PcW'(1), b1);
    step();
    cur_pc = cur_pc + PcW'(2);
  endtask

  task automatic put_jmp(logic [PcW-1:0] at, logic [PcW-1:0] tgt);
    poke(at, {bics_pkg::OP_JMP, tgt[27:24]});
    poke(at + PcW'(1), tgt[23:16]);
    poke(at + PcW'(2), tgt[15:8]);
    poke(at + PcW'(3), tgt[7:0]);
  endtask

  task automatic jump(logic [PcW-1:0] tgt);
    put_jmp(cur_pc, tgt);
    step();
    cur_pc = tgt;
  endtask

  // 4-byte control op: both exits land on a jump to a fresh spot
  task automatic ctl4(logic [31:0] ins, logic [PcW-1:0] taken);
    logic [PcW-1:0] land;
    land = PcW'($urandom);
    poke(cur_pc, ins[31:24]);
    poke(cur_pc + PcW'(1), ins[23:16]);
    poke(cur_pc + PcW'(2), ins[15:8]);
    poke(cur_pc + PcW'(3), ins[7:0]);
    put_jmp(taken, land);
    put_jmp(cur_pc + PcW'(4), land);
    step();
    step();
    cur_pc = land;
  endtask

  function automatic bit clear_of(logic [PcW-1:0] t);
    logic [AddrW-1:0] d;
    d = t[AddrW-1:0] - cur_pc[AddrW-1:0];
    return d == 4 || (d >= 8 && d <= MemBytes - 4);
  endfunction

  task automatic branch(bics_pkg::op_t op, logic [3:0] ra, logic [3:0] rb, logic [19:0] off);
    logic [PcW-1:0] t;
    t = (off == 20'd0) ? cur_pc + PcW'(4) : cur_pc + {{8{off[19]}}, off};
    ctl4({op, ra, rb, off}, t);
  endtask

  task automatic rand_branch();
    logic [19:0] off;
    logic [3:0]  ra;
    do off = 20'($urandom) & ~20'd1;
    while (off != 20'd0 && !clear_of(cur_pc + {{8{off[19]}}, off}));
    ra = 4'($urandom);
    branch($urandom_range(1) ? bics_pkg::OP_BEQ : bics_pkg::OP_BLT, ra,
           $urandom_range(2) == 0 ? ra : 4'($urandom), off);
  endtask

  task automatic rand_iter();
    logic [15:0] imm;
    do imm = 16'($urandom); while (!clear_of(cur_pc - {12'd0, imm}));
    ctl4({bics_pkg::OP_ITER, 4'($urandom), 8'($urandom), imm}, cur_pc - {12'd0, imm});
  endtask

  task automatic set_reg(logic [3:0] r, logic [7:0] k);
    exec2({bics_pkg::OP_SUB, r}, {r, r});
    exec2({bics_pkg::OP_ADDI, r}, k);
  endtask

  task automatic rand_op();
    logic [3:0] ra, rb;
    logic [7:0] k;
    ra = 4'($urandom);
    rb = 4'($urandom);
    case ($urandom_range(13))
      0: exec2({bics_pkg::OP_ADD, ra}, 8'($urandom));
      1: exec2({bics_pkg::OP_AND, ra}, 8'($urandom));
      2: begin
        do k = 8'($urandom); while (k == 8'd0);
        set_reg(rb, k);
        exec2({bics_pkg::OP_DIV, ra}, {rb, 4'($urandom)});
      end
      3: exec2({bics_pkg::OP_MUL, ra}, 8'($urandom));
      4: exec2({bics_pkg::OP_SUB, ra}, 8'($urandom));
      5: exec2({bics_pkg::OP_OR, ra}, 8'($urandom));
      6: exec2({bics_pkg::OP_SHF, ra}, 8'($urandom));
      7: begin
        case ($urandom_range(2))
          0: exec2({bics_pkg::OP_INT, 4'd0}, 8'd0);
          1: exec2({bics_pkg::OP_INT, 4'd0}, 8'd1);
          default: begin
            do k = 8'($urandom); while (ra == 4'd0 && k <= 8'd1);
            exec2({bics_pkg::OP_INT, ra}, k);
          end
        endcase
      end
      8: exec2({bics_pkg::OP_ADDI, ra}, 8'($urandom));
      9: rand_branch();
      10: jump(PcW'($urandom));
      11: rand_iter();
      12: exec2({bics_pkg::OP_LD, ra}, 8'($urandom));
      default: exec2({bics_pkg::OP_ST, ra}, 8'($urandom));
    endcase
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: dumps (first on empty registers), overflow corners, store/load, branch and jump corners
    exec2({bics_pkg::OP_INT, 4'd0}, 8'd1);
    set_reg(4'd1, 8'd1);
    exec2({bics_pkg::OP_SHF, 4'd1}, 8'd31);
    set_reg(4'd2, 8'hFF);
    exec2({bics_pkg::OP_DIV, 4'd1}, {4'd2, 4'd3});
    exec2({bics_pkg::OP_MUL, 4'd1}, {4'd2, 4'd4});
    exec2({bics_pkg::OP_SHF, 4'd1}, 8'h3F);
    exec2({bics_pkg::OP_SHF, 4'd2}, 8'h20);
    exec2({bics_pkg::OP_ADD, 4'd1}, {4'd2, 4'd5});
    exec2({bics_pkg::OP_ST, 4'd2}, {4'd1, 4'h8});
    exec2({bics_pkg::OP_LD, 4'd6}, {4'd1, 4'h7});
    exec2({bics_pkg::OP_INT, 4'd0}, 8'd0);
    exec2({bics_pkg::OP_INT, 4'd0}, 8'd1);
    exec2({bics_pkg::OP_INT, 4'hF}, 8'hFF);
    branch(bics_pkg::OP_BEQ, 4'd3, 4'd3, 20'd0);
    branch(bics_pkg::OP_BLT, 4'd4, 4'd4, 20'h00100);
    jump(28'hFFFFFFE);
    exec2({bics_pkg::OP_ADDI, 4'd7}, 8'h80);
    poke(28'd16383, 8'hFF);
    poke(28'd0, 8'h00);

    while (n_items < 340) begin
      quiet = (n_items >= 140 && n_items < 220);
      if (n_items >= 250 && !paused) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 3)) poke(PcW'($urandom), 8'($urandom));
      else
        rand_op();
    end
    quiet = 1'b0;

    // only one way to stop is reachable per run
    case ($urandom_range(2))
      0: exec2({bics_pkg::OP_HALT, 4'($urandom)}, 8'($urandom));
      1: branch(bics_pkg::OP_BEQ, 4'd8, 4'd8, 20'h00101);
      default: begin
        exec2({bics_pkg::OP_SUB, 4'd9}, {4'd9, 4'd9});
        exec2({bics_pkg::OP_DIV, 4'd3}, {4'd9, 4'd10});
      end
    endcase
    step();
    step();
    poke(PcW'($urandom), 8'($urandom));
    step();

    drain();
    repeat (60) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("[byte_isa_cpu_step_unit] OK");
    end else begin
      $display("[byte_isa_cpu_step_unit] ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bics_pkg.sv
rtl/bics_if.sv
rtl/bics_ram.sv
rtl/byte_isa_cpu_step_unit.sv
verif/bics_step_checker.sv
verif/tb.sv
